// ===== src/bmm_pkg.sv =====
// ----------------------------------------------------------------------------
// bmm_pkg: shared definitions for the banked memory mapper
// Page numbers, IO register offsets, action codes and the result word layout.
// ----------------------------------------------------------------------------
`default_nettype none

package bmm_pkg;

  // Address split: 3-bit slot, 13-bit offset inside an 8 KB page.
  localparam int OFF_W      = 13;
  localparam int SLOT_W     = 3;
  localparam int NUM_SLOTS  = 1 << SLOT_W;
  localparam int PAGE_BYTES = 1 << OFF_W;

  // ROM sizing.
  localparam int MAX_ROM_PAGES = 32;
  localparam int ROM_PAGE_W    = (MAX_ROM_PAGES > 1) ? $clog2(MAX_ROM_PAGES) : 1;
  localparam int ROM_BYTES     = MAX_ROM_PAGES * PAGE_BYTES;
  localparam int ROM_ADDR_W    = ROM_PAGE_W + OFF_W;

  // Page numbers.
  localparam logic [7:0] ROM_PAGE_LIMIT = 8'h80;
  localparam logic [7:0] RAM_PAGE       = 8'd248;
  localparam logic [7:0] IO_PAGE        = 8'd255;

  // IO page register offsets.
  localparam logic [OFF_W-1:0] TIMER_COUNT_REG = 13'd3072;
  localparam logic [OFF_W-1:0] TIMER_CTRL_REG  = TIMER_COUNT_REG + 13'd1;
  localparam logic [OFF_W-1:0] IRQ_MASK_REG    = 13'd5122;
  localparam logic [OFF_W-1:0] IRQ_STATUS_REG  = 13'd5123;
  localparam logic [OFF_W-1:0] PSG_FIRST_REG   = 13'h0800;
  localparam logic [OFF_W-1:0] PSG_LAST_REG    = 13'h0809;

  // IRQ status and mask bits.
  localparam logic [7:0] TIMER_BIT = 8'h04;
  localparam logic [7:0] VIDEO_BIT = 8'h02;

  localparam logic IRQ_KIND_TIMER = 1'b0;
  localparam logic IRQ_KIND_VIDEO = 1'b1;

  typedef enum logic [2:0] {
    ACT_READ      = 3'd0,
    ACT_WRITE     = 3'd1,
    ACT_TIMER_IRQ = 3'd2,
    ACT_VIDEO_IRQ = 3'd3,
    ACT_SET_BANK  = 3'd4,
    ACT_LOAD_ROM  = 3'd5
  } action_t;

  // Where the read byte of a pending result comes from.
  typedef enum logic [1:0] {
    RD_LOCAL,
    RD_ROM,
    RD_RAM
  } rd_sel_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       psg_write_valid;
    logic [3:0] psg_register;
    logic [7:0] psg_data;
    logic       irq_forward;
    logic       irq_kind;
  } res_t;

endpackage

`default_nettype wire

// ===== src/bmm_ifs.sv =====
// ----------------------------------------------------------------------------
// bmm_ifs: channel interfaces of the banked memory mapper
// Bus request words in, result words out, and the ROM page count write port.
// ----------------------------------------------------------------------------
`default_nettype none

interface bmm_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [15:0] address;
  logic [7:0]  data;
  logic [2:0]  bank_slot;
  logic [17:0] rom_offset;

  modport source(output valid, action, address, data, bank_slot, rom_offset, input ready);
  modport sink(input valid, action, address, data, bank_slot, rom_offset, output ready);
endinterface

interface bmm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       psg_write_valid;
  logic [3:0] psg_register;
  logic [7:0] psg_data;
  logic       irq_forward;
  logic       irq_kind;

  modport source(output valid, read_data, psg_write_valid, psg_register, psg_data,
                 irq_forward, irq_kind, input ready);
  modport sink(input valid, read_data, psg_write_valid, psg_register, psg_data,
               irq_forward, irq_kind, output ready);
endinterface

interface bmm_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] rom_pages;

  modport source(output valid, rom_pages, input ready);
  modport sink(input valid, rom_pages, output ready);
endinterface

`default_nettype wire

// ===== src/banked_memory_mapper_with_irq.sv =====
// ----------------------------------------------------------------------------
// banked_memory_mapper_with_irq: slot-to-page bank mapper with IRQ status
// Maps CPU bus accesses onto ROM, work RAM and an IO page, and collects IRQs.
// ----------------------------------------------------------------------------
// Usage:
// The in_ch channel carries one bus word per item: a read, a write, a timer
// or video IRQ event, a bank register update or a ROM byte load. Every item
// produces exactly one result word on out_ch, in order. The cfg_ch channel
// writes the loaded ROM page count; it is always ready. It is to be written only
// while no item is in flight; the block itself does not enforce this.
// An accepted item is held in the result stage, where its ROM or RAM read
// data joins it, and then moves into the output register once that register
// is free or drains. All state changes of an item happen at its accepting
// edge, and the ROM or RAM read is issued at that same edge, so a read right
// after a write sees the new byte.
// Throughput is one item per cycle while the receiver takes results; the
// rate is set by the single read port of each memory, used once per item.
// A result stage between the memories and the output register lets one new
// item enter while a finished result waits. When the receiver stalls, both
// stages fill and in_ch.ready drops until the output word is taken.
// Reset (synchronous, active low) clears the bank registers, the IRQ mask and
// status, the timer count, the page count and all valid flags. ROM and RAM
// contents are not cleared; they must be written before they are read.
// ----------------------------------------------------------------------------
`default_nettype none

module banked_memory_mapper_with_irq
  import bmm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  bmm_cfg_if.sink   cfg_ch,
  bmm_in_if.sink    in_ch,
  bmm_out_if.source out_ch
);

  // Architectural state held in flops. Timer control writes are accepted
  // but have no visible effect, since that register never reads back.
  logic [7:0] bank_r [NUM_SLOTS];
  logic [7:0] bank_nxt [NUM_SLOTS];
  logic [5:0] rom_pages_r;
  logic [6:0] timer_count_r, timer_count_nxt;
  logic [7:0] irq_mask_r, irq_mask_nxt;
  logic [7:0] irq_pending_r, irq_pending_nxt;

  // Result stage (waits for memory data) and output register.
  logic    s1_valid_r, s1_valid_nxt;
  res_t    s1_res_r, s1_res_nxt;
  rd_sel_t s1_sel_r, s1_sel_nxt;
  logic    out_valid_r, out_valid_nxt;
  res_t    out_res_r, out_res_nxt;

  logic s1_adv;
  logic in_ready;
  logic in_fire;

  // Address decode of the incoming word.
  logic [SLOT_W-1:0] slot;
  logic [OFF_W-1:0]  off;
  logic [7:0]        page;
  logic [7:0]        page_limit;
  logic [7:0]        pages_ext;

  // Memory ports.
  logic                  rom_we, rom_re;
  logic [ROM_ADDR_W-1:0] rom_raddr;
  logic [7:0]            rom_q;
  logic                  ram_we, ram_re;
  logic [7:0]            ram_q;

  assign slot = in_ch.address[OFF_W +: SLOT_W];
  assign off  = in_ch.address[OFF_W-1:0];
  assign page = bank_r[slot];

  // Page counts above the ROM size count as the full ROM.
  assign pages_ext  = {2'b00, rom_pages_r};
  assign page_limit = (pages_ext > 8'(MAX_ROM_PAGES)) ? 8'(MAX_ROM_PAGES) : pages_ext;

  assign rom_raddr = {page[ROM_PAGE_W-1:0], off};

  // The result stage moves on whenever the output register is free or drains.
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_ch.valid && in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  // Item decode: state updates, memory accesses and the local part of the
  // result, all taken at the accepting edge.
  always_comb begin
    bank_nxt        = bank_r;
    timer_count_nxt = timer_count_r;
    irq_mask_nxt    = irq_mask_r;
    irq_pending_nxt = irq_pending_r;
    s1_res_nxt      = '0;
    s1_sel_nxt      = RD_LOCAL;
    rom_we          = 1'b0;
    rom_re          = 1'b0;
    ram_we          = 1'b0;
    ram_re          = 1'b0;

    unique case (action_t'(in_ch.action))
      ACT_READ: begin
        if (page < ROM_PAGE_LIMIT) begin
          if (page < page_limit) begin
            s1_sel_nxt = RD_ROM;
            rom_re     = in_fire;
          end
        end else if (page == RAM_PAGE) begin
          s1_sel_nxt = RD_RAM;
          ram_re     = in_fire;
        end else if (page == IO_PAGE) begin
          if (off == TIMER_COUNT_REG) begin
            s1_res_nxt.read_data = {1'b0, timer_count_r};
          end else if (off == IRQ_MASK_REG) begin
            s1_res_nxt.read_data = irq_mask_r;
          end else if (off == IRQ_STATUS_REG) begin
            s1_res_nxt.read_data = irq_pending_r;
          end
        end
      end
      ACT_WRITE: begin
        if (page == RAM_PAGE) begin
          ram_we = in_fire;
        end else if (page == IO_PAGE) begin
          if (off >= PSG_FIRST_REG && off <= PSG_LAST_REG) begin
            s1_res_nxt.psg_write_valid = 1'b1;
            s1_res_nxt.psg_register    = 4'(off - PSG_FIRST_REG);
            s1_res_nxt.psg_data        = in_ch.data;
          end else if (off == TIMER_COUNT_REG) begin
            timer_count_nxt = in_ch.data[6:0];
          end else if (off == IRQ_MASK_REG) begin
            irq_mask_nxt = in_ch.data;
          end else if (off == IRQ_STATUS_REG) begin
            // Any write acknowledges the timer IRQ.
            irq_pending_nxt = irq_pending_r & ~TIMER_BIT;
          end
        end
      end
      ACT_TIMER_IRQ: begin
        irq_pending_nxt = irq_pending_r | TIMER_BIT;
        if ((irq_mask_r & TIMER_BIT) == 8'h00) begin
          s1_res_nxt.irq_forward = 1'b1;
          s1_res_nxt.irq_kind    = IRQ_KIND_TIMER;
        end
      end
      ACT_VIDEO_IRQ: begin
        // The video status bit is set and cleared within the same event, so
        // the status register itself is left alone.
        if ((irq_mask_r & VIDEO_BIT) == 8'h00) begin
          s1_res_nxt.irq_forward = 1'b1;
          s1_res_nxt.irq_kind    = IRQ_KIND_VIDEO;
        end
      end
      ACT_SET_BANK: begin
        bank_nxt[in_ch.bank_slot] = in_ch.data;
      end
      ACT_LOAD_ROM: begin
        rom_we = in_fire && ({1'b0, in_ch.rom_offset} < 19'(ROM_BYTES));
      end
      default: begin
        // Unused action codes leave state alone and give an all-zero result.
      end
    endcase
  end

  // Result stage and output register handshake.
  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;

    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = s1_res_r;
      case (s1_sel_r)
        RD_ROM:  out_res_nxt.read_data = rom_q;
        RD_RAM:  out_res_nxt.read_data = ram_q;
        default: out_res_nxt.read_data = s1_res_r.read_data;
      endcase
      s1_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        bank_r[i] <= '0;
      end
      rom_pages_r   <= '0;
      timer_count_r <= '0;
      irq_mask_r    <= '0;
      irq_pending_r <= '0;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        rom_pages_r <= cfg_ch.rom_pages;
      end
      if (in_fire) begin
        bank_r        <= bank_nxt;
        timer_count_r <= timer_count_nxt;
        irq_mask_r    <= irq_mask_nxt;
        irq_pending_r <= irq_pending_nxt;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_res_r <= s1_res_nxt;
      s1_sel_r <= s1_sel_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  // ROM: written by ROM loads, read by mapped ROM pages.
  bmm_ram #(
    .WIDTH(8),
    .DEPTH(ROM_BYTES)
  ) u_rom (
    .clk  (clk),
    .we   (rom_we),
    .waddr(in_ch.rom_offset[ROM_ADDR_W-1:0]),
    .wdata(in_ch.data),
    .re   (rom_re),
    .raddr(rom_raddr),
    .rdata(rom_q)
  );

  // Work RAM: one 8 KB page.
  bmm_ram #(
    .WIDTH(8),
    .DEPTH(PAGE_BYTES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(off),
    .wdata(in_ch.data),
    .re   (ram_re),
    .raddr(off),
    .rdata(ram_q)
  );

  assign out_ch.valid           = out_valid_r;
  assign out_ch.read_data       = out_res_r.read_data;
  assign out_ch.psg_write_valid = out_res_r.psg_write_valid;
  assign out_ch.psg_register    = out_res_r.psg_register;
  assign out_ch.psg_data        = out_res_r.psg_data;
  assign out_ch.irq_forward     = out_res_r.irq_forward;
  assign out_ch.irq_kind        = out_res_r.irq_kind;

endmodule

`default_nettype wire

// ===== src/bmm_ram.sv =====
// ----------------------------------------------------------------------------
// bmm_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered and holds its
// value until the next read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module bmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/bmm_checker.sv =====
// ----------------------------------------------------------------------------
// bmm_checker: port-level checks for the banked memory mapper
// Watches the result channel and the input handshake over time.
// ----------------------------------------------------------------------------
`default_nettype none

module bmm_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] read_data,
  input wire logic       psg_write_valid,
  input wire logic [3:0] psg_register,
  input wire logic [7:0] psg_data,
  input wire logic       irq_forward,
  input wire logic       irq_kind
);

  // A result word waiting on a stalled receiver does not change.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(read_data) &&
      $stable(psg_write_valid) && $stable(psg_register) && $stable(psg_data) &&
      $stable(irq_forward) && $stable(irq_kind))
    else $error("result word changed while stalled");

  // No result word is shown in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A sound write never shares its result word with an IRQ or with read data.
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && psg_write_valid |-> !irq_forward && read_data == 8'h00)
    else $error("sound write result mixed with other fields");

  // Fields of an absent sound write or IRQ read as zero, and a sound write names register 0 to 9.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (psg_write_valid || (psg_register == 4'd0 && psg_data == 8'h00)) &&
      (irq_forward || !irq_kind) && (!psg_write_valid || psg_register <= 4'd9))
    else $error("result fields out of range");

  // With both stages full and the receiver stalled, no input is taken.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready && $past(out_valid && !out_ready) &&
      $past(in_valid && in_ready) |-> !in_ready)
    else $error("input accepted with no room for its result");

endmodule

bind banked_memory_mapper_with_irq bmm_checker u_bmm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .read_data      (out_ch.read_data),
  .psg_write_valid(out_ch.psg_write_valid),
  .psg_register   (out_ch.psg_register),
  .psg_data       (out_ch.psg_data),
  .irq_forward    (out_ch.irq_forward),
  .irq_kind       (out_ch.irq_kind)
);

`default_nettype wire
